>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character decode function of the base64url
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Width of the byte count field on the result channel.
	localparam int LEN_OUT_W = 24;

	// Default width of the internal byte counter.
	localparam int LENGTH_BITS_DEF = 24;

	// Configuration register indexes.
	localparam logic [7:0] REG_CHAR_62 = 8'd0;
	localparam logic [7:0] REG_CHAR_63 = 8'd1;

	// Register reset values.
	localparam logic [7:0] CHAR_MINUS      = 8'h2D;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

	// Fixed characters of the alphabet.
	localparam logic [7:0] CHAR_EQUALS = 8'h3D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

	typedef logic [5:0] sextet_t;

	typedef struct packed {
		logic    bad;
		sextet_t value;
	} sextet_dec_t;

	// Maps one character to its 6-bit value. Letters and digits win over the
	// two programmable codes, and '=' always marks the character as bad.
	function automatic sextet_dec_t decode_char(input logic [7:0] c,
			input logic [7:0] c62, input logic [7:0] c63);
		sextet_dec_t d;
		logic [7:0]  off;
		d   = '{bad: 1'b1, value: '0};
		off = '0;
		if (c == CHAR_EQUALS) begin
			d.bad = 1'b1;
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			off = c - CHAR_UPPER_A;
			d   = '{bad: 1'b0, value: off[5:0]};
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			off = c - CHAR_LOWER_A + 8'd26;
			d   = '{bad: 1'b0, value: off[5:0]};
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			off = c - CHAR_DIGIT_0 + 8'd52;
			d   = '{bad: 1'b0, value: off[5:0]};
		end else if (c == c62) begin
			d = '{bad: 1'b0, value: 6'd62};
		end else if (c == c63) begin
			d = '{bad: 1'b0, value: 6'd63};
		end
		return d;
	endfunction

endpackage

>>> hw/rtl/b64d_char_if.sv
// ----------------------------------------------------------------------------
// b64d_char_if
// Character channel: one encoded character per request, with an end flag.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_message;

	modport source(output valid, char_in, end_of_message, input ready);
	modport sink(input valid, char_in, end_of_message, output ready);
endinterface

>>> hw/rtl/b64d_byte_if.sv
// ----------------------------------------------------------------------------
// b64d_byte_if
// Result channel: one decoded byte or end marker per request.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        byte_present;
	logic        final_result;
	logic [23:0] total_length;

	modport source(output valid, byte_out, byte_present, final_result, total_length,
		input ready);
	modport sink(input valid, byte_out, byte_present, final_result, total_length,
		output ready);
endinterface

>>> hw/rtl/b64d_cfg_if.sv
// ----------------------------------------------------------------------------
// b64d_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface b64d_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] reg_index;
	logic [7:0] wdata;

	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

>>> hw/rtl/base64url_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Decodes a base64url character stream into bytes, one character per request.
// ----------------------------------------------------------------------------
// One character is taken per clock when the decoder is ready for it. A
// character that yields bytes loads them into a three-entry result buffer that
// drains one byte per cycle while the sink is ready. Such a character is taken
// once that buffer is empty or its last entry leaves. A character that yields
// nothing is taken in the cycle it arrives, even while the buffer drains. The
// final character of a message flushes a partial group; if that character
// yields no byte at all, a single end marker without data is sent. The last
// result of each message carries the byte count, which saturates at
// 2^LENGTH_BITS - 1. The two programmable alphabet codes may be written at any
// time the decoder is idle.
// ----------------------------------------------------------------------------
module base64url_stream_decoder #(
	parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	b64d_cfg_if.sink    cfg,
	b64d_char_if.sink   chars,
	b64d_byte_if.source bytes
);
	import b64d_pkg::*;

	typedef logic [LENGTH_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	function automatic count_t sat_add(input count_t c, input logic [1:0] n);
		logic [LENGTH_BITS:0] sum;
		sum = {1'b0, c} + {{(LENGTH_BITS-1){1'b0}}, n};
		return sum[LENGTH_BITS] ? COUNT_MAX : sum[LENGTH_BITS-1:0];
	endfunction

	// Configuration and decoder state.
	logic [7:0]  c62_q, c63_q;
	logic [17:0] pend_q;
	logic [1:0]  pend_cnt_q;
	logic        stopped_q;
	count_t      count_q;

	// Result buffer.
	logic [7:0]  buf_q [3];
	logic [1:0]  buf_cnt_q;
	logic        present_q;
	logic        final_q;
	count_t      len_q;

	sextet_dec_t dec;
	logic        accept, take, use_char, full_group, last, marker;
	logic [17:0] pend_n;
	logic [1:0]  pend_cnt_n, n_bytes;
	logic [23:0] group;

	assign cfg.ready   = 1'b1;
	// A request that yields nothing never touches the result buffer.
	assign chars.ready = (n_bytes == 2'd0 && !marker) || (buf_cnt_q == 2'd0) ||
		(buf_cnt_q == 2'd1 && bytes.ready);
	assign accept      = chars.valid && chars.ready;
	assign take        = bytes.valid && bytes.ready;
	assign last        = chars.end_of_message;

	assign dec        = decode_char(chars.char_in, c62_q, c63_q);
	assign use_char   = !stopped_q && !dec.bad;
	assign full_group = use_char && pend_cnt_q == 2'd3;

	always_comb begin
		pend_n     = pend_q;
		pend_cnt_n = pend_cnt_q;
		if (full_group) begin
			pend_n     = '0;
			pend_cnt_n = 2'd0;
		end else if (use_char) begin
			pend_n     = {pend_q[11:0], dec.value};
			pend_cnt_n = pend_cnt_q + 2'd1;
		end
		// A completed group and a flush never happen together: the group
		// leaves nothing pending.
		if (full_group) begin
			n_bytes = 2'd3;
			group   = {pend_q, dec.value};
		end else if (last && pend_cnt_n == 2'd3) begin
			n_bytes = 2'd2;
			group   = {pend_n, 6'd0};
		end else if (last && pend_cnt_n == 2'd2) begin
			n_bytes = 2'd1;
			group   = {pend_n[11:0], 12'd0};
		end else begin
			n_bytes = 2'd0;
			group   = '0;
		end
	end

	assign marker = last && n_bytes == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c62_q <= CHAR_MINUS;
			c63_q <= CHAR_UNDERSCORE;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_CHAR_62: c62_q <= cfg.wdata;
				REG_CHAR_63: c63_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= 2'd0;
			stopped_q  <= 1'b0;
			count_q    <= '0;
			buf_cnt_q  <= 2'd0;
			present_q  <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			if (take) begin
				buf_cnt_q <= buf_cnt_q - 2'd1;
			end
			if (accept) begin
				pend_q     <= last ? 18'd0 : pend_n;
				pend_cnt_q <= last ? 2'd0 : pend_cnt_n;
				stopped_q  <= !last && (stopped_q || dec.bad);
				count_q    <= last ? '0 : sat_add(count_q, n_bytes);
				if (n_bytes != 2'd0 || marker) begin
					buf_cnt_q <= marker ? 2'd1 : n_bytes;
					present_q <= !marker;
					final_q   <= last;
				end
			end
		end
	end

	// Payload of the result buffer: loaded on a request that yields results,
	// shifted down as the sink takes each byte.
	always_ff @(posedge clk) begin
		if (accept && (n_bytes != 2'd0 || marker)) begin
			buf_q[0] <= group[23:16];
			buf_q[1] <= group[15:8];
			buf_q[2] <= group[7:0];
			len_q    <= marker ? count_q : sat_add(count_q, 2'd1);
		end else if (take) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			len_q    <= sat_add(len_q, 2'd1);
		end
	end

	assign bytes.valid        = buf_cnt_q != 2'd0;
	assign bytes.byte_out     = buf_q[0];
	assign bytes.byte_present = present_q;
	assign bytes.final_result = final_q && buf_cnt_q == 2'd1;
	assign bytes.total_length = LEN_OUT_W'(len_q);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the base64url stream decoder against a cycle-free predictor that
// tracks held sextets, the stop flag and the byte count. A directed table
// comes first, then random messages under several alphabet settings, with
// bursty input, a stalling byte sink and one long sink hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import b64d_pkg::*;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_ITEMS  = 14;
	localparam int          NUM_PHASES    = 5;
	localparam int          DRAIN_CYCLES  = 12;
	localparam logic [6:0]  NOT_SEXTET    = 7'd64;
	localparam logic [23:0] COUNT_MAX     = 24'hFFFFFF;

	typedef struct packed {
		logic [7:0]  data;
		logic        present;
		logic        is_final;
		logic [23:0] count;
	} byte_res_t;

	typedef struct packed {
		logic [7:0] c;
		logic       eom;
		logic       typed;
		byte_res_t  want;
	} char_req_t;

	localparam byte_res_t NO_TYPED = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_off = 1'b0;
	bit   holdoff_armed = 1'b0;

	b64d_cfg_if  cfg_ch();
	b64d_char_if char_ch();
	b64d_byte_if byte_ch();

	base64url_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.chars(char_ch),
		.bytes(byte_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state and its copy of the alphabet registers.
	logic [7:0]  code62;
	logic [7:0]  code63;
	logic [17:0] held_sextets;
	logic [1:0]  held_count;
	logic        halted;
	logic [23:0] byte_total;

	char_req_t char_stream[$];
	byte_res_t decoded_q[$];

	int errors;
	int cycle_count;
	int items_sent;
	int bytes_seen;
	int markers_seen;
	int messages_seen;

	// Short stimulus table: extremes of the alphabet, stops, flushes and
	// bare end markers. Typed rows give one obvious result.
	char_req_t directed_tbl [25] = '{
		'{"=",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 24'd0}},
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 24'd0}},
		'{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 24'd0}},
		'{"A",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 24'd0}},
		'{"A",   1'b0, 1'b0, NO_TYPED},
		'{"A",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 24'd1}},
		'{"_",   1'b0, 1'b0, NO_TYPED},
		'{"_",   1'b0, 1'b0, NO_TYPED},
		'{"-",   1'b0, 1'b0, NO_TYPED},
		'{"-",   1'b1, 1'b0, NO_TYPED},
		'{"Z",   1'b0, 1'b0, NO_TYPED},
		'{"a",   1'b0, 1'b0, NO_TYPED},
		'{"z",   1'b0, 1'b0, NO_TYPED},
		'{"9",   1'b0, 1'b0, NO_TYPED},
		'{"0",   1'b0, 1'b0, NO_TYPED},
		'{"=",   1'b0, 1'b0, NO_TYPED},
		'{"Q",   1'b0, 1'b0, NO_TYPED},
		'{"x",   1'b1, 1'b0, NO_TYPED},
		'{"A",   1'b0, 1'b0, NO_TYPED},
		'{"B",   1'b0, 1'b0, NO_TYPED},
		'{"C",   1'b0, 1'b0, NO_TYPED},
		'{"!",   1'b1, 1'b0, NO_TYPED},
		'{"g",   1'b0, 1'b0, NO_TYPED},
		'{"8",   1'b0, 1'b0, NO_TYPED},
		'{"=",   1'b1, 1'b0, NO_TYPED}
	};

	logic [7:0] phase_code62 [NUM_PHASES] = '{CHAR_MINUS, 8'h00, 8'h2B, CHAR_EQUALS, 8'h7E};
	logic [7:0] phase_code63 [NUM_PHASES] = '{CHAR_UNDERSCORE, 8'hFF, 8'h2B, CHAR_UPPER_A,
		8'h80};

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] off;
		off = '0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			off = c - CHAR_UPPER_A;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			off = c - CHAR_LOWER_A + 8'd26;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			off = c - CHAR_DIGIT_0 + 8'd52;
		end else if (c == code62) begin
			off = 8'd62;
		end else if (c == code63) begin
			off = 8'd63;
		end else begin
			off = 8'd64;
		end
		return off[6:0];
	endfunction

	function automatic byte_res_t count_byte(input logic [7:0] b);
		if (byte_total != COUNT_MAX)
			byte_total = byte_total + 24'd1;
		return '{data: b, present: 1'b1, is_final: 1'b0, count: byte_total};
	endfunction

	// Advances the predictor by one character and returns the bytes it causes.
	function automatic int decode_char_step(input logic [7:0] c, input logic eom,
			output byte_res_t res [3]);
		logic [6:0]  v;
		logic [23:0] grp;
		int          n;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		if (!halted) begin
			v = (c == CHAR_EQUALS) ? NOT_SEXTET : sextet_of(c);
			if (v == NOT_SEXTET) begin
				halted = 1'b1;
			end else if (held_count == 2'd3) begin
				grp    = {held_sextets, v[5:0]};
				res[0] = count_byte(grp[23:16]);
				res[1] = count_byte(grp[15:8]);
				res[2] = count_byte(grp[7:0]);
				n      = 3;
				held_sextets = '0;
				held_count   = '0;
			end else begin
				held_sextets = {held_sextets[11:0], v[5:0]};
				held_count   = held_count + 2'd1;
			end
		end
		if (eom) begin
			// Missing sextets of a partial group are taken as zero.
			if (held_count >= 2'd2) begin
				grp = (held_count == 2'd3) ? {held_sextets, 6'd0} : {held_sextets[11:0], 12'd0};
				res[n] = count_byte(grp[23:16]);
				n++;
				if (held_count == 2'd3) begin
					res[n] = count_byte(grp[15:8]);
					n++;
				end
			end
			if (n == 0) begin
				res[0] = '{data: 8'h00, present: 1'b0, is_final: 1'b1, count: byte_total};
				n = 1;
			end else begin
				res[n - 1].is_final = 1'b1;
			end
			held_sextets = '0;
			held_count   = '0;
			halted       = 1'b0;
			byte_total   = '0;
		end
		return n;
	endfunction

	function automatic logic [7:0] pick_alphabet_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26)
			return CHAR_UPPER_A + 8'(r);
		else if (r < 52)
			return CHAR_LOWER_A + 8'(r - 26);
		else if (r < 62)
			return CHAR_DIGIT_0 + 8'(r - 52);
		else if (r == 62)
			return code62;
		return code63;
	endfunction

	// Queues one message and returns the number of characters in it. Most
	// messages are clean, some break in the middle, a few are pure noise.
	function automatic int queue_random_message();
		int         kind;
		int         len;
		int         i;
		int         first;
		logic [7:0] c;
		first = char_stream.size();
		kind  = $urandom_range(0, 9);
		len   = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 11);
		for (i = 0; i < len; i++) begin
			if (kind <= 6 || (kind <= 8 && i != len / 2))
				c = pick_alphabet_char();
			else if (kind <= 8)
				c = ($urandom_range(0, 1) != 0) ? CHAR_EQUALS : 8'($urandom_range(0, 255));
			else
				c = 8'($urandom_range(0, 255));
			char_stream.push_back('{c, 1'b0, 1'b0, NO_TYPED});
		end
		case ($urandom_range(0, 3))
			0, 1: begin
				if (len > 0)
					char_stream[$].eom = 1'b1;
				else
					char_stream.push_back('{pick_alphabet_char(), 1'b1, 1'b0, NO_TYPED});
			end
			2: char_stream.push_back('{CHAR_EQUALS, 1'b1, 1'b0, NO_TYPED});
			default: char_stream.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_TYPED});
		endcase
		return char_stream.size() - first;
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// Both alphabet registers are written back to back; valid drops once.
	task automatic write_alphabet(input logic [7:0] v62, input logic [7:0] v63);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= REG_CHAR_62;
		cfg_ch.wdata     <= v62;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.reg_index <= REG_CHAR_63;
		cfg_ch.wdata     <= v63;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		code62 = v62;
		code63 = v63;
	endtask

	// Sends the queued characters in bursts and predicts each accepted one.
	task automatic send_chars();
		char_req_t req;
		byte_res_t res [3];
		int        burst;
		int        gap;
		int        n;
		int        i;
		while (char_stream.size() != 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && char_stream.size() != 0) begin
				req = char_stream.pop_front();
				char_ch.valid          <= 1'b1;
				char_ch.char_in        <= req.c;
				char_ch.end_of_message <= req.eom;
				do @(posedge clk); while (!char_ch.ready);
				items_sent++;
				n = decode_char_step(req.c, req.eom, res);
				if (req.typed) begin
					decoded_q.push_back(req.want);
				end else begin
					for (i = 0; i < n; i++)
						decoded_q.push_back(res[i]);
				end
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0 && char_stream.size() != 0) begin
				char_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		char_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Byte sink: switches at random between four stall patterns.
	initial begin : byte_sink
		int mode;
		int left;
		byte_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 80);
			end
			left--;
			if (hold_off) begin
				byte_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: byte_ch.ready <= 1'b1;
					1: byte_ch.ready <= ($urandom_range(0, 3) != 0);
					2: byte_ch.ready <= 1'($urandom_range(0, 1));
					default: byte_ch.ready <= ((left % 7) > 2);
				endcase
			end
		end
	end

	// One long sink hold-off while the sender keeps offering characters,
	// so the result buffer fills and the decoder stalls its input.
	initial begin : long_holdoff
		wait (holdoff_armed);
		repeat ($urandom_range(2, 10)) @(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		byte_res_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected result", {16'd0, byte_ch.byte_out}, 24'd0);
			end else begin
				want = decoded_q.pop_front();
				if (byte_ch.byte_out !== want.data)
					report_mismatch("byte_out", {16'd0, byte_ch.byte_out}, {16'd0, want.data});
				if (byte_ch.byte_present !== want.present)
					report_mismatch("byte_present", {23'd0, byte_ch.byte_present},
						{23'd0, want.present});
				if (byte_ch.final_result !== want.is_final)
					report_mismatch("final_result", {23'd0, byte_ch.final_result},
						{23'd0, want.is_final});
				if (byte_ch.total_length !== want.count)
					report_mismatch("total_length", byte_ch.total_length, want.count);
			end
			if (byte_ch.byte_present)
				bytes_seen++;
			else
				markers_seen++;
			if (byte_ch.final_result)
				messages_seen++;
		end
	end

	initial begin : main
		int phase;
		int queued;
		int i;
		arst_n                 = 1'b0;
		char_ch.valid          = 1'b0;
		char_ch.char_in        = '0;
		char_ch.end_of_message = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.reg_index       = REG_CHAR_62;
		cfg_ch.wdata           = '0;
		code62       = CHAR_MINUS;
		code63       = CHAR_UNDERSCORE;
		held_sextets = '0;
		held_count   = '0;
		halted       = 1'b0;
		byte_total   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0) begin
				for (i = 0; i < 25; i++)
					char_stream.push_back(directed_tbl[i]);
			end else begin
				write_alphabet(phase_code62[phase], phase_code63[phase]);
			end
			if (phase == 1)
				holdoff_armed = 1'b1;
			queued = 0;
			while (queued < RANDOM_ITEMS)
				queued += queue_random_message();
			send_chars();
			wait_drained();
		end

		$display("sent %0d characters over %0d alphabet settings", items_sent, NUM_PHASES);
		$display("checked %0d bytes and %0d bare end markers in %0d messages",
			bytes_seen, markers_seen, messages_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
